// File: hw/rtl/pkhd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pkhd_pkg: shared types and constants for the profile distance block
// Field widths, register indexes, configuration struct and the state type
// of the distance engine.
// ----------------------------------------------------------------------------
package pkhd_pkg;

	// Payload widths
	localparam int ALLELE_W = 32;
	localparam int ID_W     = 16;
	localparam int DIST_W   = 17;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 17;

	localparam logic [CFG_IDX_W-1:0] REG_SCALED        = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT_MISSING = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FILTER_EN     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD     = 2'd3;

	// 1.0 in the scaled distance format
	localparam logic [DIST_W-1:0] SCALE_ONE = 17'h10000;

	// One integer quotient bit plus sixteen fraction bits
	localparam int DIV_STEPS = DIST_W;
	localparam int STEP_W    = $clog2(DIV_STEPS);

	typedef struct packed {
		logic              scaled;
		logic              zero_is_data;
		logic              filter_en;
		logic [DIST_W-1:0] threshold;
	} cfg_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_EMIT
	} back_state_t;

endpackage
`default_nettype wire

// File: hw/rtl/pkhd_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pkhd_front: locus accumulator
// Takes a locus pair per cycle while not full, keeps the saturating mismatch
// and compared counts, and queues a finished pair as a job on its last locus.
// ----------------------------------------------------------------------------
module pkhd_front import pkhd_pkg::*; #(
	parameter int MAX_LOCI = 4096,
	parameter int CNT_W    = 13
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire cfg_t                cfg,
	input  wire logic                push,
	output logic                     full,
	input  wire logic [ALLELE_W-1:0] first_allele,
	input  wire logic [ALLELE_W-1:0] second_allele,
	input  wire logic                last_locus,
	input  wire logic [ID_W-1:0]     query_index,
	input  wire logic [ID_W-1:0]     reference_index,
	output logic                     job_push,
	input  wire logic                job_full,
	output logic [ID_W-1:0]          job_qid,
	output logic [ID_W-1:0]          job_rid,
	output logic [CNT_W-1:0]         job_mismatch,
	output logic [CNT_W-1:0]         job_compared
);

	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_LOCI);

	logic             accept;
	logic             use_locus;
	logic [CNT_W-1:0] mismatch_q;
	logic [CNT_W-1:0] compared_q;
	logic [CNT_W-1:0] mismatch_d;
	logic [CNT_W-1:0] compared_d;

	// Stall the whole stream while the job queue has no room.
	assign full   = job_full;
	assign accept = push && !job_full;

	// A locus counts unless one side is missing and missing codes are skipped.
	assign use_locus = cfg.zero_is_data
		|| ((first_allele != '0) && (second_allele != '0));

	// Saturating updates of both counts.
	always_comb begin
		compared_d = compared_q;
		mismatch_d = mismatch_q;
		if (use_locus) begin
			if (compared_q != CNT_MAX) begin
				compared_d = compared_q + CNT_W'(1);
			end
			if ((first_allele != second_allele) && (mismatch_q != CNT_MAX)) begin
				mismatch_d = mismatch_q + CNT_W'(1);
			end
		end
	end

	// The job carries the counts including the last locus itself.
	assign job_push     = accept && last_locus;
	assign job_qid      = query_index;
	assign job_rid      = reference_index;
	assign job_mismatch = mismatch_d;
	assign job_compared = compared_d;

	// Counters clear once a pair has been handed on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mismatch_q <= '0;
			compared_q <= '0;
		end else if (accept) begin
			if (last_locus) begin
				mismatch_q <= '0;
				compared_q <= '0;
			end else begin
				mismatch_q <= mismatch_d;
				compared_q <= compared_d;
			end
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/pkhd_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pkhd_queue: two-entry job queue
// Decouples the locus accumulator from the distance engine so that each
// side can stall on its own.
// ----------------------------------------------------------------------------
module pkhd_queue #(
	parameter int WIDTH = 58
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      rdata,
	output logic                  empty
);

	logic [WIDTH-1:0] entry_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == 2'd2);
	assign empty   = (count_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = entry_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= wdata;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/pkhd_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pkhd_back: distance engine
// Turns a finished pair into its distance (scaled mode: bit-serial restoring
// divider), applies the threshold filter and holds the result for the reader.
// ----------------------------------------------------------------------------
module pkhd_back import pkhd_pkg::*; #(
	parameter int CNT_W = 13
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cfg_t             cfg,
	input  wire logic             job_empty,
	output logic                  job_pop,
	input  wire logic [ID_W-1:0]  job_qid,
	input  wire logic [ID_W-1:0]  job_rid,
	input  wire logic [CNT_W-1:0] job_mismatch,
	input  wire logic [CNT_W-1:0] job_compared,
	output logic                  res_empty,
	input  wire logic             res_pop,
	output logic [ID_W-1:0]       query_id,
	output logic [ID_W-1:0]       reference_id,
	output logic [DIST_W-1:0]     pair_distance
);

	back_state_t       state_q;
	back_state_t       state_d;
	logic [ID_W-1:0]   qid_q;
	logic [ID_W-1:0]   rid_q;
	logic [CNT_W-1:0]  div_q;
	logic [CNT_W:0]    rem_q;
	logic [DIST_W-1:0] quo_q;
	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;
	logic [CNT_W:0]    trial;
	logic [CNT_W:0]    diff;
	logic              ge;
	logic              last_step;
	logic              slot_free;
	logic              drop;
	logic              emit;

	// One quotient bit per step; the first step takes the integer bit unshifted.
	assign trial     = (step_q == '0) ? rem_q : {rem_q[CNT_W-1:0], 1'b0};
	assign diff      = trial - {1'b0, div_q};
	assign ge        = (trial >= {1'b0, div_q});
	assign last_step = (step_q == STEP_W'(DIV_STEPS - 1));

	// Output slot handling and the threshold filter.
	assign slot_free = !out_valid_q || res_pop;
	assign drop      = cfg.filter_en && (quo_q > cfg.threshold);
	assign emit      = (state_q == BK_EMIT) && !drop && slot_free;

	// Next state and control outputs
	always_comb begin
		state_d = state_q;
		job_pop = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (!job_empty) begin
					job_pop = 1'b1;
					if (cfg.scaled && (job_compared != '0)) begin
						state_d = BK_DIV;
					end else begin
						state_d = BK_EMIT;
					end
				end
			end
			BK_DIV: begin
				if (last_step) begin
					state_d = BK_EMIT;
				end
			end
			BK_EMIT: begin
				if (drop || slot_free) begin
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (res_pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Divider datapath; the quotient register doubles as the distance.
	always_ff @(posedge clk) begin
		if (job_pop) begin
			qid_q  <= job_qid;
			rid_q  <= job_rid;
			div_q  <= job_compared;
			rem_q  <= {1'b0, job_mismatch};
			step_q <= '0;
			if (!cfg.scaled) begin
				quo_q <= DIST_W'(job_mismatch);
			end else if (job_compared == '0) begin
				quo_q <= SCALE_ONE;
			end else begin
				quo_q <= '0;
			end
		end else if (state_q == BK_DIV) begin
			rem_q  <= ge ? diff : trial;
			quo_q  <= {quo_q[DIST_W-2:0], ge};
			step_q <= step_q + STEP_W'(1);
		end
	end

	// Result register seen by the reader
	always_ff @(posedge clk) begin
		if (emit) begin
			query_id      <= qid_q;
			reference_id  <= rid_q;
			pair_distance <= quo_q;
		end
	end

	assign res_empty = !out_valid_q;

endmodule
`default_nettype wire

// File: hw/rtl/profile_hamming_distance.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// profile_hamming_distance: allele profile distance with missing values
// Streams locus pairs, counts mismatches over compared loci and reports the
// distance of each unfiltered pair, raw or as a fraction of compared loci.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue: drive one locus pair with push; it is taken on a
//   clock edge where full is low. last_locus closes the profile pair and its
//   query_index and reference_index are echoed in the result.
//   Result side is a queue: while empty is low the oldest result is on
//   query_id, reference_id and pair_distance; pop takes it.
//   Configuration (cfg_write, cfg_index, cfg_data) is written while idle.
// Timing:
//   One locus pair is accepted every cycle while full is low. A closed pair
//   enters a two-entry job queue. The distance engine pops one pair at a
//   time, runs the one-bit-per-cycle divider (17 steps) in scaled mode when
//   loci were compared, and then emits the result into the output slot.
// Reset and stalls:
//   arst_n clears the counts, the job queue, the result slot and loads the
//   register defaults. While pop stays low one result waits in the slot, the
//   engine and job queue fill up behind it, then full rises.
// ----------------------------------------------------------------------------
module profile_hamming_distance import pkhd_pkg::*; #(
	parameter int MAX_LOCI = 4096
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_write,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  push,
	output logic                       full,
	input  wire logic [ALLELE_W-1:0]   first_allele,
	input  wire logic [ALLELE_W-1:0]   second_allele,
	input  wire logic                  last_locus,
	input  wire logic [ID_W-1:0]       query_index,
	input  wire logic [ID_W-1:0]       reference_index,
	output logic                       empty,
	input  wire logic                  pop,
	output logic [ID_W-1:0]            query_id,
	output logic [ID_W-1:0]            reference_id,
	output logic [DIST_W-1:0]          pair_distance
);

	localparam int CNT_W = $clog2(MAX_LOCI + 1);
	localparam int JOB_W = 2 * ID_W + 2 * CNT_W;

	cfg_t             cfg_q;
	logic             job_push;
	logic             job_full;
	logic             job_pop;
	logic             job_empty;
	logic [ID_W-1:0]  f_qid;
	logic [ID_W-1:0]  f_rid;
	logic [CNT_W-1:0] f_mismatch;
	logic [CNT_W-1:0] f_compared;
	logic [ID_W-1:0]  b_qid;
	logic [ID_W-1:0]  b_rid;
	logic [CNT_W-1:0] b_mismatch;
	logic [CNT_W-1:0] b_compared;
	logic [JOB_W-1:0] job_wdata;
	logic [JOB_W-1:0] job_rdata;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scaled       <= 1'b0;
			cfg_q.zero_is_data <= 1'b0;
			cfg_q.filter_en    <= 1'b0;
			cfg_q.threshold    <= SCALE_ONE;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_SCALED:        cfg_q.scaled       <= cfg_data[0];
				REG_COUNT_MISSING: cfg_q.zero_is_data <= cfg_data[0];
				REG_FILTER_EN:     cfg_q.filter_en    <= cfg_data[0];
				REG_THRESHOLD:     cfg_q.threshold    <= cfg_data[DIST_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Front: locus accumulator
	pkhd_front #(
		.MAX_LOCI (MAX_LOCI),
		.CNT_W    (CNT_W)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.push            (push),
		.full            (full),
		.first_allele    (first_allele),
		.second_allele   (second_allele),
		.last_locus      (last_locus),
		.query_index     (query_index),
		.reference_index (reference_index),
		.job_push        (job_push),
		.job_full        (job_full),
		.job_qid         (f_qid),
		.job_rid         (f_rid),
		.job_mismatch    (f_mismatch),
		.job_compared    (f_compared)
	);

	// Job queue between the two sides
	assign job_wdata = {f_qid, f_rid, f_mismatch, f_compared};
	assign {b_qid, b_rid, b_mismatch, b_compared} = job_rdata;

	pkhd_queue #(
		.WIDTH (JOB_W)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.wdata  (job_wdata),
		.full   (job_full),
		.pop    (job_pop),
		.rdata  (job_rdata),
		.empty  (job_empty)
	);

	// Back: distance engine and result slot
	pkhd_back #(
		.CNT_W (CNT_W)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.job_empty     (job_empty),
		.job_pop       (job_pop),
		.job_qid       (b_qid),
		.job_rid       (b_rid),
		.job_mismatch  (b_mismatch),
		.job_compared  (b_compared),
		.res_empty     (empty),
		.res_pop       (pop),
		.query_id      (query_id),
		.reference_id  (reference_id),
		.pair_distance (pair_distance)
	);

endmodule
`default_nettype wire

// File: hw/rtl/pkhd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pkhd_checker: port-level checks for the profile distance block
// Watches the top-level ports for reset behavior, result holding, distance
// range and what makes the input side stall.
// ----------------------------------------------------------------------------
module pkhd_checker import pkhd_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              push,
	input wire logic              full,
	input wire logic              last_locus,
	input wire logic              empty,
	input wire logic              pop,
	input wire logic [ID_W-1:0]   query_id,
	input wire logic [ID_W-1:0]   reference_id,
	input wire logic [DIST_W-1:0] pair_distance
);

	logic last_request;

	assign last_request = push && !full && last_locus;

	// Coming out of reset nothing is waiting and the input side is open.
	a_reset_clean: assert property (@(posedge clk)
		$rose(arst_n) |-> (empty && !full))
		else $error("result or full flag present right after reset");

	// A waiting result holds until it is popped.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable({query_id, reference_id, pair_distance})))
		else $error("waiting result changed before pop");

	// A waiting distance never exceeds SCALE_ONE, 1.0 in scaled form, in raw or scaled mode.
	a_distance_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (pair_distance <= SCALE_ONE))
		else $error("pair distance out of range");

	// Only a closed pair entering the job queue can make the input side stall.
	a_full_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(last_request))
		else $error("full rose without a last locus request");

endmodule

bind profile_hamming_distance pkhd_checker u_pkhd_checker (.*);
`default_nettype wire

// File: tb/sv/tb_profile_hamming_distance.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_profile_hamming_distance: self-checking bench for the profile distance
// Streams locus pairs into the block, predicts each pair distance with a
// local model of the counts and registers, and compares every result in
// order. Covers raw and scaled modes, missing codes, filtering, register
// masking, backpressure and random traffic.
// ----------------------------------------------------------------------------
module tb_profile_hamming_distance;
	import pkhd_pkg::*;

	localparam int LOCI_CAP      = 4096;
	localparam int SETTLE_CYCLES = 80;
	localparam int QUIET_LIMIT   = 1000;

	typedef struct {
		logic [ALLELE_W-1:0] allele_a;
		logic [ALLELE_W-1:0] allele_b;
		logic                closes_pair;
		logic [ID_W-1:0]     qidx;
		logic [ID_W-1:0]     ridx;
	} locus_t;

	typedef struct {
		logic [ID_W-1:0]   qid;
		logic [ID_W-1:0]   rid;
		logic [DIST_W-1:0] distance;
	} distance_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  push = 1'b0;
	logic                  full;
	logic [ALLELE_W-1:0]   first_allele = '0;
	logic [ALLELE_W-1:0]   second_allele = '0;
	logic                  last_locus = 1'b0;
	logic [ID_W-1:0]       query_index = '0;
	logic [ID_W-1:0]       reference_index = '0;
	logic                  empty;
	logic                  pop = 1'b0;
	logic [ID_W-1:0]       query_id;
	logic [ID_W-1:0]       reference_id;
	logic [DIST_W-1:0]     pair_distance;

	// Local copy of the registers and the running counts
	logic              mode_scaled = 1'b0;
	logic              mode_zero_data = 1'b0;
	logic              mode_filter = 1'b0;
	logic [DIST_W-1:0] keep_limit = SCALE_ONE;
	int unsigned       mismatch_cnt = 0;
	int unsigned       compared_cnt = 0;

	distance_t   distance_q[$];
	int unsigned fault_count = 0;
	int unsigned sent_count = 0;
	bit          idle_sender = 1'b0;
	bit          idle_results = 1'b0;
	int          hold_request = 0;

	profile_hamming_distance #(
		.MAX_LOCI(LOCI_CAP)
	) i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.push           (push),
		.full           (full),
		.first_allele   (first_allele),
		.second_allele  (second_allele),
		.last_locus     (last_locus),
		.query_index    (query_index),
		.reference_index(reference_index),
		.empty          (empty),
		.pop            (pop),
		.query_id       (query_id),
		.reference_id   (reference_id),
		.pair_distance  (pair_distance)
	);

	// 10 ns clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Counts stop at the locus cap.
	function automatic int unsigned capped_inc(int unsigned v);
		return (v < LOCI_CAP) ? v + 1 : LOCI_CAP;
	endfunction

	// Fold one accepted locus into the counts; a closing locus may queue a distance.
	function automatic void fold_locus(locus_t lc);
		logic      counted;
		logic [DIST_W-1:0] new_dist;
		distance_t res;
		counted = mode_zero_data || (lc.allele_a != 0 && lc.allele_b != 0);
		if (counted) begin
			compared_cnt = capped_inc(compared_cnt);
			if (lc.allele_a != lc.allele_b)
				mismatch_cnt = capped_inc(mismatch_cnt);
		end
		if (!lc.closes_pair)
			return;
		if (!mode_scaled)
			new_dist = DIST_W'(mismatch_cnt);
		else if (compared_cnt == 0)
			new_dist = SCALE_ONE;
		else
			new_dist = DIST_W'((longint'(mismatch_cnt) * 65536) / compared_cnt);
		mismatch_cnt = 0;
		compared_cnt = 0;
		if (mode_filter && new_dist > keep_limit)
			return;
		res.qid      = lc.qidx;
		res.rid      = lc.ridx;
		res.distance = new_dist;
		distance_q.insert(distance_q.size(), res);
	endfunction

	function automatic void note_fault(string what, int unsigned want, int unsigned got);
		fault_count++;
		if (fault_count <= 10)
			$display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, want, got);
	endfunction

	// Compare one popped result with the oldest expected distance.
	function automatic void check_distance();
		distance_t want;
		if (distance_q.size() == 0) begin
			fault_count++;
			if (fault_count <= 10)
				$display("%0t: unexpected result: query %0d reference %0d distance %0d",
					$realtime, query_id, reference_id, pair_distance);
			return;
		end
		want = distance_q.pop_front();
		if (query_id !== want.qid)
			note_fault("query_id", want.qid, query_id);
		if (reference_id !== want.rid)
			note_fault("reference_id", want.rid, reference_id);
		if (pair_distance !== want.distance)
			note_fault("pair_distance", want.distance, pair_distance);
	endfunction

	// Offer one locus, with an optional idle burst first, and wait until it is taken.
	task automatic send_locus(input logic [ALLELE_W-1:0] a, input logic [ALLELE_W-1:0] b,
		input logic closes, input logic [ID_W-1:0] q, input logic [ID_W-1:0] r);
		locus_t lc;
		int     gap;
		lc.allele_a    = a;
		lc.allele_b    = b;
		lc.closes_pair = closes;
		lc.qidx        = q;
		lc.ridx        = r;
		if (idle_sender && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 12);
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push            <= 1'b1;
		first_allele    <= a;
		second_allele   <= b;
		last_locus      <= closes;
		query_index     <= q;
		reference_index <= r;
		do
			@(posedge clk);
		while (full);
		fold_locus(lc);
		sent_count++;
	endtask

	// Wait until every expected distance is back and the engine has gone quiet.
	task automatic wait_idle();
		push <= 1'b0;
		while (distance_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			REG_SCALED:        mode_scaled = val[0];
			REG_COUNT_MISSING: mode_zero_data = val[0];
			REG_FILTER_EN:     mode_filter = val[0];
			REG_THRESHOLD:     keep_limit = val[DIST_W-1:0];
			default: ;
		endcase
	endtask

	// Write all four registers; only legal while the block is idle.
	task automatic program_regs(input logic [CFG_DATA_W-1:0] d_scaled,
		input logic [CFG_DATA_W-1:0] d_missing, input logic [CFG_DATA_W-1:0] d_filter,
		input logic [CFG_DATA_W-1:0] d_limit);
		write_reg(REG_SCALED, d_scaled);
		write_reg(REG_COUNT_MISSING, d_missing);
		write_reg(REG_FILTER_EN, d_filter);
		write_reg(REG_THRESHOLD, d_limit);
		cfg_write <= 1'b0;
	endtask

	// Allele codes mix missing, small shared codes and full-width values.
	function automatic logic [ALLELE_W-1:0] draw_allele();
		case ($urandom_range(0, 6))
			0:       return '0;
			1, 2:    return $urandom_range(1, 3);
			3:       return '1;
			default: return $urandom();
		endcase
	endfunction

	// A one-bit register value with random junk in the unused upper bits.
	function automatic logic [CFG_DATA_W-1:0] with_junk(logic v);
		logic [CFG_DATA_W-2:0] junk;
		junk = (CFG_DATA_W-1)'($urandom_range(0, 65535));
		return {junk, v};
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_limit(logic scaled);
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return SCALE_ONE;
			2:       return '1;
			default: return scaled ? CFG_DATA_W'($urandom_range(0, 65536))
				: CFG_DATA_W'($urandom_range(0, 6));
		endcase
	endfunction

	// One profile pair of random loci; indices on the earlier loci are noise.
	task automatic send_random_pair(input int loci);
		logic [ALLELE_W-1:0] a;
		logic [ALLELE_W-1:0] b;
		for (int k = 0; k < loci; k++) begin
			a = draw_allele();
			b = ($urandom_range(0, 9) < 4) ? a : draw_allele();
			send_locus(a, b, k == loci - 1, ID_W'($urandom_range(0, 65535)),
				ID_W'($urandom_range(0, 65535)));
		end
	endtask

	task automatic random_phase(input int items);
		int unsigned stop_at;
		int unsigned next_mix;
		stop_at  = sent_count + items;
		next_mix = sent_count;
		while (sent_count < stop_at) begin
			if (sent_count >= next_mix) begin
				idle_sender  = $urandom_range(0, 2) != 0;
				idle_results = $urandom_range(0, 2) != 0;
				next_mix     = sent_count + 50;
			end
			send_random_pair(($urandom_range(0, 9) == 0) ? $urandom_range(7, 40)
				: $urandom_range(1, 6));
		end
	endtask

	// Raw counts from reset values: missing codes, extremes, echoed indices.
	task automatic test_raw_counts();
		send_locus(32'd5, 32'd5, 1'b0, 16'd1, 16'd2);
		send_locus(32'd0, 32'd7, 1'b0, 16'd3, 16'd4);
		send_locus(32'hFFFF_FFFF, 32'd0, 1'b0, 16'd5, 16'd6);
		send_locus(32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b0, 16'd7, 16'd8);
		send_locus(32'd0, 32'd0, 1'b1, 16'hFFFF, 16'h0000);
		// No loci compared gives a raw distance of zero.
		send_locus(32'd0, 32'd3, 1'b1, 16'h0000, 16'hFFFF);
		wait_idle();
	endtask

	// Scaled distances, the empty pair and counting of missing codes.
	task automatic test_scaled_and_missing();
		program_regs(17'd1, 17'd0, 17'd0, SCALE_ONE);
		send_locus(32'd0, 32'd0, 1'b1, 16'd1234, 16'd4321);
		send_locus(32'd1, 32'd2, 1'b0, 16'd0, 16'd0);
		send_locus(32'd3, 32'd3, 1'b0, 16'd0, 16'd0);
		send_locus(32'd4, 32'd4, 1'b1, 16'd7, 16'd9);
		wait_idle();
		program_regs(17'd1, 17'd1, 17'd0, SCALE_ONE);
		send_locus(32'd0, 32'd0, 1'b0, 16'd1, 16'd1);
		send_locus(32'd0, 32'd5, 1'b1, 16'd2, 16'd2);
		send_locus(32'd1, 32'd2, 1'b1, 16'd3, 16'd3);
		wait_idle();
	endtask

	// Filtered pairs still clear the counts; the largest threshold drops nothing.
	task automatic test_filter();
		program_regs(17'd0, 17'd0, 17'd1, 17'd1);
		send_locus(32'd1, 32'd2, 1'b0, 16'd10, 16'd11);
		send_locus(32'd3, 32'd4, 1'b1, 16'd12, 16'd13);
		send_locus(32'd5, 32'd5, 1'b1, 16'd14, 16'd15);
		wait_idle();
		program_regs(17'd1, 17'd0, 17'd1, 17'd0);
		send_locus(32'd1, 32'd2, 1'b1, 16'd20, 16'd21);
		send_locus(32'd8, 32'd8, 1'b1, 16'd22, 16'd23);
		wait_idle();
		program_regs(17'd1, 17'd0, 17'd1, '1);
		send_locus(32'd1, 32'd2, 1'b1, 16'd30, 16'd31);
		wait_idle();
	endtask

	// Bits above a register's width are ignored.
	task automatic test_register_masking();
		program_regs(17'h1FFFE, 17'h0FFFE, 17'h1FFFF, SCALE_ONE);
		send_locus(32'd0, 32'd9, 1'b0, 16'd40, 16'd41);
		send_locus(32'd1, 32'd2, 1'b1, 16'd42, 16'd43);
		wait_idle();
	endtask

	// The result side holds off while short pairs keep coming, so full must rise.
	task automatic test_backpressure();
		program_regs(17'd0, 17'd0, 17'd0, SCALE_ONE);
		idle_sender  = 1'b0;
		hold_request = 150;
		for (int k = 0; k < 60; k++)
			send_locus($urandom_range(0, 3), $urandom_range(0, 3), 1'b1,
				ID_W'($urandom_range(0, 65535)), ID_W'($urandom_range(0, 65535)));
		wait_idle();
	endtask

	// Random traffic over every combination of the mode bits.
	task automatic test_random_traffic();
		logic [CFG_DATA_W-1:0] limit;
		for (int p = 0; p < 8; p++) begin
			limit = pick_limit(p[0]);
			program_regs(with_junk(p[0]), with_junk(p[1]), with_junk(p[2]), limit);
			random_phase(215);
			wait_idle();
		end
	endtask

	// Closing stretch at full rate on both sides.
	task automatic test_full_rate();
		program_regs(CFG_DATA_W'($urandom_range(0, 1)), CFG_DATA_W'($urandom_range(0, 1)),
			17'd0, SCALE_ONE);
		idle_sender  = 1'b0;
		idle_results = 1'b0;
		while (sent_count < 1950)
			send_random_pair($urandom_range(1, 6));
		wait_idle();
	endtask

	// Result side: check each popped result, then choose pop for the next cycle.
	initial begin : result_side
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && pop && !empty)
				check_distance();
			if (hold_request != 0) begin
				stall_left   = hold_request;
				hold_request = 0;
			end
			if (stall_left > 0) begin
				stall_left--;
				pop <= 1'b0;
			end else if (idle_results && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(0, 11);
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// Watchdog: too many cycles without any request moving on either side.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb_profile_hamming_distance: errors");
		$finish;
	end

	// Test sequence.
	initial begin : sequence_main
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_raw_counts();
		test_scaled_and_missing();
		test_filter();
		test_register_masking();
		idle_sender  = 1'b1;
		idle_results = 1'b1;
		test_backpressure();
		test_random_traffic();
		test_full_rate();
		if (fault_count == 0)
			$display("tb_profile_hamming_distance: clean");
		else
			$display("tb_profile_hamming_distance: errors");
		$finish;
	end

endmodule
